### rtl/core/seg_pkg.sv
// ----------------------------------------------------------------------------
// seg_pkg
// Shared widths and beat types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package seg_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int OUT_BITS   = 24;

	// difference, product, cross-product widths
	localparam int D_W = COORD_BITS + 1;
	localparam int P_W = 2 * D_W;
	localparam int N_W = P_W + 1;
	// divider remainder (one spare bit for the shift) and quotient
	localparam int R_W = N_W + 1;
	localparam int Q_W = FRAC_BITS + 1;
	// crossing sum before clamp
	localparam int S_W = COORD_BITS + FRAC_BITS + 4;

	// front end to divider
	typedef struct packed {
		logic                         hit;
		logic [N_W-1:0]               num;
		logic [N_W-1:0]               den;
		logic signed [COORD_BITS-1:0] ax0;
		logic signed [COORD_BITS-1:0] ay0;
		logic signed [D_W-1:0]        dax;
		logic signed [D_W-1:0]        day;
	} seg_div_in_t;

	// divider to back end
	typedef struct packed {
		logic                         hit;
		logic [Q_W-1:0]               tq;
		logic signed [COORD_BITS-1:0] ax0;
		logic signed [COORD_BITS-1:0] ay0;
		logic signed [D_W-1:0]        dax;
		logic signed [D_W-1:0]        day;
	} seg_div_out_t;

endpackage

`default_nettype wire

### rtl/core/seg_front.sv
// ----------------------------------------------------------------------------
// seg_front
// Differences, cross products, numerators and the hit test (four stages).
// ----------------------------------------------------------------------------
`default_nettype none

module seg_front (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] a_start_x,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] a_start_y,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] a_end_x,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] a_end_y,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] b_start_x,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] b_start_y,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] b_end_x,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] b_end_y,
	output logic                                       out_valid,
	output seg_pkg::seg_div_in_t                       out_beat
);
	import seg_pkg::*;

	logic                         v_s1, v_s2, v_s3, v_s4;
	logic signed [COORD_BITS-1:0] ax0_s1, ay0_s1, ax0_s2, ay0_s2, ax0_s3, ay0_s3;
	logic signed [D_W-1:0]        dax_s1, day_s1, dbx_s1, dby_s1, ox_s1, oy_s1;
	logic signed [D_W-1:0]        dax_s2, day_s2, dax_s3, day_s3;
	logic signed [P_W-1:0]        pd1_s2, pd2_s2, ps1_s2, ps2_s2, pt1_s2, pt2_s2;
	logic signed [N_W-1:0]        den_s3, snum_s3, tnum_s3;
	seg_div_in_t                  beat_s4;

	logic pos, s_neg, t_neg, s_gt, t_gt, hit_c;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: direction and offset differences
	always_ff @(posedge clk) begin
		ax0_s1 <= a_start_x;
		ay0_s1 <= a_start_y;
		dax_s1 <= D_W'(a_end_x) - D_W'(a_start_x);
		day_s1 <= D_W'(a_end_y) - D_W'(a_start_y);
		dbx_s1 <= D_W'(b_end_x) - D_W'(b_start_x);
		dby_s1 <= D_W'(b_end_y) - D_W'(b_start_y);
		ox_s1  <= D_W'(a_start_x) - D_W'(b_start_x);
		oy_s1  <= D_W'(a_start_y) - D_W'(b_start_y);
	end

	// stage 2: six products
	always_ff @(posedge clk) begin
		ax0_s2 <= ax0_s1;
		ay0_s2 <= ay0_s1;
		dax_s2 <= dax_s1;
		day_s2 <= day_s1;
		pd1_s2 <= P_W'(dax_s1) * P_W'(dby_s1);
		pd2_s2 <= P_W'(dbx_s1) * P_W'(day_s1);
		ps1_s2 <= P_W'(dax_s1) * P_W'(oy_s1);
		ps2_s2 <= P_W'(day_s1) * P_W'(ox_s1);
		pt1_s2 <= P_W'(dbx_s1) * P_W'(oy_s1);
		pt2_s2 <= P_W'(dby_s1) * P_W'(ox_s1);
	end

	// stage 3: denominator and numerators
	always_ff @(posedge clk) begin
		ax0_s3  <= ax0_s2;
		ay0_s3  <= ay0_s2;
		dax_s3  <= dax_s2;
		day_s3  <= day_s2;
		den_s3  <= N_W'(pd1_s2) - N_W'(pd2_s2);
		snum_s3 <= N_W'(ps1_s2) - N_W'(ps2_s2);
		tnum_s3 <= N_W'(pt1_s2) - N_W'(pt2_s2);
	end

	// sign-dependent range test
	always_comb begin
		pos   = !den_s3[N_W-1] && (den_s3 != '0);
		s_neg = snum_s3[N_W-1];
		t_neg = tnum_s3[N_W-1];
		s_gt  = snum_s3 > den_s3;
		t_gt  = tnum_s3 > den_s3;
		hit_c = (den_s3 != '0) && (s_neg != pos) && (t_neg != pos) &&
			(s_gt != pos) && (t_gt != pos);
	end

	// stage 4: hit flag and magnitudes for the divider
	always_ff @(posedge clk) begin
		beat_s4.hit <= hit_c;
		beat_s4.num <= t_neg ? N_W'(-tnum_s3) : N_W'(tnum_s3);
		beat_s4.den <= den_s3[N_W-1] ? N_W'(-den_s3) : N_W'(den_s3);
		beat_s4.ax0 <= ax0_s3;
		beat_s4.ay0 <= ay0_s3;
		beat_s4.dax <= dax_s3;
		beat_s4.day <= day_s3;
	end

	assign out_valid = v_s4;
	assign out_beat  = beat_s4;

endmodule

`default_nettype wire

### rtl/core/seg_div.sv
// ----------------------------------------------------------------------------
// seg_div
// Pipelined restoring divider: one quotient bit per stage, Q_W stages.
// ----------------------------------------------------------------------------
`default_nettype none

module seg_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire seg_pkg::seg_div_in_t  in_beat,
	output logic                       out_valid,
	output seg_pkg::seg_div_out_t      out_beat
);
	import seg_pkg::*;

	logic                         v_s   [Q_W+1];
	logic [R_W-1:0]               rem_s [Q_W+1];
	logic [Q_W-1:0]               q_s   [Q_W+1];
	logic [N_W-1:0]               den_s [Q_W+1];
	logic                         hit_s [Q_W+1];
	logic signed [COORD_BITS-1:0] ax0_s [Q_W+1];
	logic signed [COORD_BITS-1:0] ay0_s [Q_W+1];
	logic signed [D_W-1:0]        dax_s [Q_W+1];
	logic signed [D_W-1:0]        day_s [Q_W+1];

	// stage 0 is the input beat
	always_comb begin
		v_s[0]   = in_valid;
		rem_s[0] = R_W'(in_beat.num);
		q_s[0]   = '0;
		den_s[0] = in_beat.den;
		hit_s[0] = in_beat.hit;
		ax0_s[0] = in_beat.ax0;
		ay0_s[0] = in_beat.ay0;
		dax_s[0] = in_beat.dax;
		day_s[0] = in_beat.day;
	end

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		logic [R_W-1:0] r;
		logic           ge;

		// first stage gives the integer bit, the rest shift first
		always_comb begin
			r  = (i == 0) ? rem_s[i] : (rem_s[i] << 1);
			ge = r >= R_W'(den_s[i]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? (r - R_W'(den_s[i])) : r;
			q_s[i+1]   <= {q_s[i][Q_W-2:0], ge};
			den_s[i+1] <= den_s[i];
			hit_s[i+1] <= hit_s[i];
			ax0_s[i+1] <= ax0_s[i];
			ay0_s[i+1] <= ay0_s[i];
			dax_s[i+1] <= dax_s[i];
			day_s[i+1] <= day_s[i];
		end
	end

	assign out_valid    = v_s[Q_W];
	assign out_beat.hit = hit_s[Q_W];
	assign out_beat.tq  = q_s[Q_W];
	assign out_beat.ax0 = ax0_s[Q_W];
	assign out_beat.ay0 = ay0_s[Q_W];
	assign out_beat.dax = dax_s[Q_W];
	assign out_beat.day = day_s[Q_W];

endmodule

`default_nettype wire

### rtl/core/seg_back.sv
// ----------------------------------------------------------------------------
// seg_back
// Crossing point A.start*2^FRAC + t*dA, clamped and gated by hit.
// ----------------------------------------------------------------------------
`default_nettype none

module seg_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire seg_pkg::seg_div_out_t               in_beat,
	output logic                                     done,
	output logic                                     hit,
	output logic signed [seg_pkg::OUT_BITS-1:0]      cross_x,
	output logic signed [seg_pkg::OUT_BITS-1:0]      cross_y
);
	import seg_pkg::*;

	localparam logic signed [S_W-1:0] OUT_MAX = S_W'((64'sd1 <<< (OUT_BITS - 1)) - 1);
	localparam logic signed [S_W-1:0] OUT_MIN = S_W'(-(64'sd1 <<< (OUT_BITS - 1)));

	logic                  v_s1, hit_s1;
	logic signed [S_W-1:0] bx_s1, by_s1, mx_s1, my_s1;
	logic signed [S_W-1:0] sx, sy;
	logic                  v_s2, hit_s2;
	logic signed [OUT_BITS-1:0] x_s2, y_s2;

	// stage 1: t * dA and scaled start
	always_ff @(posedge clk) begin
		hit_s1 <= in_beat.hit;
		bx_s1  <= S_W'(in_beat.ax0) <<< FRAC_BITS;
		by_s1  <= S_W'(in_beat.ay0) <<< FRAC_BITS;
		mx_s1  <= S_W'($signed({1'b0, in_beat.tq})) * S_W'(in_beat.dax);
		my_s1  <= S_W'($signed({1'b0, in_beat.tq})) * S_W'(in_beat.day);
	end

	always_comb begin
		sx = bx_s1 + mx_s1;
		sy = by_s1 + my_s1;
	end

	// stage 2: sum, clamp, zero on miss
	always_ff @(posedge clk) begin
		hit_s2 <= hit_s1;
		if (!hit_s1) begin
			x_s2 <= '0;
		end else if (sx > OUT_MAX) begin
			x_s2 <= OUT_BITS'(OUT_MAX);
		end else if (sx < OUT_MIN) begin
			x_s2 <= OUT_BITS'(OUT_MIN);
		end else begin
			x_s2 <= OUT_BITS'(sx);
		end
		if (!hit_s1) begin
			y_s2 <= '0;
		end else if (sy > OUT_MAX) begin
			y_s2 <= OUT_BITS'(OUT_MAX);
		end else if (sy < OUT_MIN) begin
			y_s2 <= OUT_BITS'(OUT_MIN);
		end else begin
			y_s2 <= OUT_BITS'(sy);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	assign done    = v_s2;
	assign hit     = hit_s2;
	assign cross_x = x_s2;
	assign cross_y = y_s2;

endmodule

`default_nettype wire

### rtl/core/segment_intersection_unit.sv
// ----------------------------------------------------------------------------
// segment_intersection_unit
// Pipeline from start to done: 4 front stages, 9 divider stages
// (one quotient bit each), 2 back stages. Throughput one beat per cycle;
// busy is always low and done pulses for one cycle per beat.
// Reset clears only the valid bits; no state is kept between beats.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] a_start_x,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] a_start_y,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] a_end_x,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] a_end_y,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] b_start_x,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] b_start_y,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] b_end_x,
	input  wire logic signed [seg_pkg::COORD_BITS-1:0] b_end_y,
	output logic                                       done,
	output logic                                       hit,
	output logic signed [seg_pkg::OUT_BITS-1:0]        cross_x,
	output logic signed [seg_pkg::OUT_BITS-1:0]        cross_y
);
	import seg_pkg::*;

	logic          fr_valid, dv_valid;
	seg_div_in_t   fr_beat;
	seg_div_out_t  dv_beat;

	// fully pipelined, never stalls
	assign busy = 1'b0;

	seg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.a_start_x (a_start_x),
		.a_start_y (a_start_y),
		.a_end_x   (a_end_x),
		.a_end_y   (a_end_y),
		.b_start_x (b_start_x),
		.b_start_y (b_start_y),
		.b_end_x   (b_end_x),
		.b_end_y   (b_end_y),
		.out_valid (fr_valid),
		.out_beat  (fr_beat)
	);

	seg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_beat   (fr_beat),
		.out_valid (dv_valid),
		.out_beat  (dv_beat)
	);

	seg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dv_valid),
		.in_beat  (dv_beat),
		.done     (done),
		.hit      (hit),
		.cross_x  (cross_x),
		.cross_y  (cross_y)
	);

endmodule

`default_nettype wire
